>>> rtl/cwm_pkg.sv
// shared types, constants and calendar functions of the civil time window matcher
package cwm_pkg;

    // calendar and clock limits
    localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;
    localparam logic [13:0] MAX_YEAR        = 14'd9999;
    localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
    localparam logic [5:0]  MINUTES_PER_HR  = 6'd60;
    localparam logic [4:0]  LEAP_FEB_DAYS   = 5'd29;
    localparam logic [3:0]  MONTHS          = 4'd12;
    localparam logic [3:0]  FEBRUARY        = 4'd2;
    localparam logic [2:0]  WEEKDAY_NONE    = 3'd7;

    // divisibility by 25 on 14 bits: multiply by the inverse of 25 mod 2^14
    localparam logic [13:0] INV25       = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT = 14'd655;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // result status codes
    localparam logic [1:0] ST_CHECKED     = 2'd0;
    localparam logic [1:0] ST_BAD_WINDOW  = 2'd1;
    localparam logic [1:0] ST_BAD_TIME    = 2'd2;
    localparam logic [1:0] ST_LOADED      = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_MASK  = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // packed date, year in the high bits
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    // token handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        is_load;
        logic [2:0]  slot;
        date_t       today;
        logic        load_ok;
        logic [3:0]  count;
        logic        hit;
        logic        bad;
    } link_t;

    // gregorian leap rule
    function automatic logic is_leap(input logic [13:0] y);
        logic [13:0] prod;
        logic        div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // month length, zero for a month out of range
    function automatic logic [4:0] days_in(input logic [13:0] y, input logic [3:0] m);
        logic [4:0] len;
        if (m == 4'd0 || m > MONTHS)
            len = 5'd0;
        else if (m == FEBRUARY && is_leap(y))
            len = LEAP_FEB_DAYS;
        else
            len = MONTH_LEN[m - 4'd1];
        return len;
    endfunction

    // full date validity
    function automatic logic gregorian_ok(input date_t d);
        return (d.year != 14'd0) && (d.year <= MAX_YEAR) && (d.day != 5'd0)
            && (d.day <= days_in(d.year, d.month));
    endfunction

endpackage

>>> rtl/cwm_query_if.sv
// query channel of the window matcher: one load or check item
interface cwm_query_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [2:0]  slot;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute_of_hour;

    modport source (
        output valid, req_type, slot, year, month, day, weekday, hour, minute_of_hour,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot, year, month, day, weekday, hour, minute_of_hour,
        output ready
    );
endinterface

>>> rtl/cwm_answer_if.sv
// answer channel of the window matcher: one result item
interface cwm_answer_if;
    logic       valid;
    logic       ready;
    logic       in_window;
    logic [1:0] status;

    modport source (
        output valid, in_window, status,
        input  ready
    );
    modport sink (
        input  valid, in_window, status,
        output ready
    );
endinterface

>>> rtl/civil_time_window_matcher.sv
// top level of the civil time window matcher
//
// Usage: items arrive on the query channel (valid/ready). A load item
// (req_type 0) writes year/month/day into a date slot and answers status 3.
// A check item (req_type 1) answers whether hour:minute lies in
// [window start, window end) on a selected weekday or date, or status 1
// (window settings invalid) or status 2 (time fields invalid).
// Registers are written on the cfg port (cfg_we, cfg_index, cfg_data); the user
// must write them only while no item is in flight: the block does not enforce it.
// An item passes a start register, then walks a chain of DATE_SLOTS cells,
// one cell per cycle; its answer is registered after the last cell.
// One item is in the chain at a time: a new item is not accepted until the
// answer of the last one has left the chain tail.
// The answer sits in an output register with one spare entry behind it, so
// the next item is accepted while an answer still waits. While the receiver
// stalls with both full, query ready stays low.
// Reset clears the configuration registers, all date slots and their validity flags.
module civil_time_window_matcher #(
    parameter int unsigned DATE_SLOTS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    cwm_query_if.sink     query,
    cwm_answer_if.source  answer,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [10:0]   cfg_data
);

    localparam logic [3:0] SLOTS_4 = 4'(DATE_SLOTS);

    // configuration registers
    logic [10:0] win_start_reg;
    logic [10:0] win_end_reg;
    logic [6:0]  weekday_mask_reg;
    logic [3:0]  date_count_reg;

    // item held for the whole walk
    logic           req_type_reg;
    logic [2:0]     slot_reg;
    cwm_pkg::date_t date_reg;
    logic [2:0]     weekday_reg;
    logic [4:0]     hour_reg;
    logic [5:0]     minute_reg;

    logic busy_reg;
    logic start_reg;

    // answer register and one spare
    logic       ans_valid_reg;
    logic       ans_hit_reg;
    logic [1:0] ans_status_reg;
    logic       pend_valid_reg;
    logic       pend_hit_reg;
    logic [1:0] pend_status_reg;

    cwm_pkg::link_t links [DATE_SLOTS+1];
    logic [DATE_SLOTS-1:0] chain_valid;

    logic        accept;
    logic        can_load;
    logic        date_ok;
    logic        base_ok;
    logic        time_ok;
    logic [10:0] now;
    logic        in_range;
    logic        sel_hit;
    logic        res_hit;
    logic [1:0]  res_status;

    assign accept   = query.valid && query.ready;
    assign query.ready = !busy_reg;
    assign can_load = !ans_valid_reg || answer.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg    <= '0;
            win_end_reg      <= '0;
            weekday_mask_reg <= '0;
            date_count_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cwm_pkg::CFG_START: win_start_reg    <= cfg_data;
                cwm_pkg::CFG_END:   win_end_reg      <= cfg_data;
                cwm_pkg::CFG_MASK:  weekday_mask_reg <= cfg_data[6:0];
                cwm_pkg::CFG_COUNT: date_count_reg   <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    // capture item fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg   <= query.req_type;
            slot_reg       <= query.slot;
            date_reg.year  <= query.year;
            date_reg.month <= query.month;
            date_reg.day   <= query.day;
            weekday_reg    <= query.weekday;
            hour_reg       <= query.hour;
            minute_reg     <= query.minute_of_hour;
        end
    end

    // field checks on the held item
    assign date_ok = cwm_pkg::gregorian_ok(date_reg);
    assign time_ok = date_ok && (hour_reg < cwm_pkg::HOURS_PER_DAY)
                  && (minute_reg < cwm_pkg::MINUTES_PER_HR);
    assign now     = ({6'd0, hour_reg} * 11'd60) + {5'd0, minute_reg};
    assign in_range = (now >= win_start_reg) && (now < win_end_reg);
    assign base_ok = (win_start_reg < cwm_pkg::MINUTES_PER_DAY)
                  && (win_end_reg < cwm_pkg::MINUTES_PER_DAY)
                  && (win_start_reg < win_end_reg)
                  && !((weekday_mask_reg != 7'd0) && (date_count_reg != 4'd0))
                  && (date_count_reg <= SLOTS_4);

    // token entering the chain
    always_comb
    begin
        links[0].valid   = start_reg;
        links[0].is_load = (req_type_reg == cwm_pkg::REQ_LOAD);
        links[0].slot    = slot_reg;
        links[0].today   = date_reg;
        links[0].load_ok = date_ok;
        links[0].count   = date_count_reg;
        links[0].hit     = 1'b0;
        links[0].bad     = 1'b0;
    end

    // chain of date slots
    for (genvar i = 0; i < DATE_SLOTS; i++)
    begin : g_cell
        cwm_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
        assign chain_valid[i] = links[i+1].valid;
    end

    // day selection and final decision at the chain tail
    always_comb
    begin
        if (weekday_mask_reg != 7'd0)
            sel_hit = (weekday_reg != cwm_pkg::WEEKDAY_NONE) && weekday_mask_reg[weekday_reg];
        else if (date_count_reg == 4'd0)
            sel_hit = 1'b1;
        else
            sel_hit = links[DATE_SLOTS].hit;

        res_hit = 1'b0;
        if (links[DATE_SLOTS].is_load)
            res_status = cwm_pkg::ST_LOADED;
        else if (!base_ok || links[DATE_SLOTS].bad)
            res_status = cwm_pkg::ST_BAD_WINDOW;
        else if (!time_ok)
            res_status = cwm_pkg::ST_BAD_TIME;
        else
        begin
            res_status = cwm_pkg::ST_CHECKED;
            res_hit    = in_range && sel_hit;
        end
    end

    // item tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept;
            if (accept)
                busy_reg <= 1'b1;
            else if (can_load && (links[DATE_SLOTS].valid || pend_valid_reg))
                busy_reg <= 1'b0;
        end
    end

    // answer register with a spare entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ans_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_load)
                ans_valid_reg <= links[DATE_SLOTS].valid || pend_valid_reg;
            if (links[DATE_SLOTS].valid && !can_load)
                pend_valid_reg <= 1'b1;
            else if (can_load)
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && pend_valid_reg)
        begin
            ans_hit_reg    <= pend_hit_reg;
            ans_status_reg <= pend_status_reg;
        end
        else if (can_load && links[DATE_SLOTS].valid)
        begin
            ans_hit_reg    <= res_hit;
            ans_status_reg <= res_status;
        end
        if (links[DATE_SLOTS].valid && !can_load)
        begin
            pend_hit_reg    <= res_hit;
            pend_status_reg <= res_status;
        end
    end

    assign answer.valid     = ans_valid_reg;
    assign answer.in_window = ans_hit_reg;
    assign answer.status    = ans_status_reg;

`ifndef NO_ASSERTIONS
    // at most one token walks the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one token in the chain");

    // a token leaves the chain only for an item in flight
    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        links[DATE_SLOTS].valid |-> busy_reg)
        else $error("chain tail without an item in flight");

    // the spare entry is used only behind a full answer register
    a_pend_behind: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ans_valid_reg)
        else $error("spare answer filled while answer register empty");

    // an accepted item starts a token next cycle
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (start_reg && busy_reg))
        else $error("accepted item did not enter the chain");

    // a load never reports a hit
    a_load_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        (ans_valid_reg && (ans_status_reg == cwm_pkg::ST_LOADED)) |-> !ans_hit_reg)
        else $error("load answer with in_window set");
`endif

endmodule

>>> rtl/cwm_cell.sv
// one date slot of the matcher chain: stores a date, checks a passing token
module cwm_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cwm_pkg::link_t link_in,
    output cwm_pkg::link_t link_out
);

    localparam logic [3:0] SLOT_ID = 4'(INDEX);

    cwm_pkg::date_t date_reg;
    logic           ok_reg;
    cwm_pkg::link_t link_reg;
    cwm_pkg::link_t link_next;

    logic write_en;
    logic in_use;

    // slot write by a load token addressed here
    assign write_en = link_in.valid && link_in.is_load && ({1'b0, link_in.slot} == SLOT_ID);
    // slot counts toward a check while inside the selected range
    assign in_use   = (SLOT_ID < link_in.count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg <= '0;
            ok_reg   <= 1'b0;
        end
        else if (write_en)
        begin
            date_reg <= link_in.today;
            ok_reg   <= link_in.load_ok;
        end
    end

    // fold this slot into the token
    always_comb
    begin
        link_next = link_in;
        if (!link_in.is_load && in_use)
        begin
            link_next.hit = link_in.hit | (date_reg == link_in.today);
            link_next.bad = link_in.bad | !ok_reg;
        end
    end

    // hand the token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_reg <= '0;
        else
            link_reg <= link_next;
    end

    assign link_out = link_reg;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the civil time window matcher: directed and random items
module tb_top;

    localparam int SLOT_COUNT    = 8;
    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ROUNDS = 20;
    localparam int ROUND_ITEMS   = 40;
    localparam int MAX_REPORTS   = 30;
    localparam int DAY_MINUTES   = 1440;

    typedef struct {
        logic           req_type;
        logic [2:0]     slot;
        cwm_pkg::date_t date;
        logic [2:0]     weekday;
        logic [4:0]     hour;
        logic [5:0]     minute;
    } query_t;

    typedef struct {
        logic       in_window;
        logic [1:0] status;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    cwm_query_if  query_ch ();
    cwm_answer_if answer_ch ();

    civil_time_window_matcher #(
        .DATE_SLOTS (SLOT_COUNT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query_ch),
        .answer    (answer_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // window settings and date table as the block should hold them
    int             win_start;
    int             win_end;
    logic [6:0]     day_mask;
    int             dates_used;
    cwm_pkg::date_t slot_date [SLOT_COUNT];
    bit             slot_date_ok [SLOT_COUNT];

    query_t  pending_queries [$];
    answer_t answers_due [$];
    query_t  current_query;

    bit q_taken;
    bit q_busy;
    int q_gap;
    int a_gap;
    bit idling_on;
    int errors;
    int cycle_count;
    int n_hit, n_miss, n_bad_window, n_bad_time, n_loaded;

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // gregorian leap rule
    function automatic bit leap_rule(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // length of a month, zero when the month is out of range
    function automatic int days_of_month(input int y, input int m);
        int len;
        case (m)
            2:                     len = leap_rule(y) ? 29 : 28;
            4, 6, 9, 11:           len = 30;
            1, 3, 5, 7, 8, 10, 12: len = 31;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_is_valid(input cwm_pkg::date_t d);
        int y;
        int m;
        int dd;
        y  = int'(d.year);
        m  = int'(d.month);
        dd = int'(d.day);
        return (y >= 1) && (y <= 9999) && (dd >= 1) && (dd <= days_of_month(y, m));
    endfunction

    // bounds, selection mode and every date slot in use
    function automatic bit window_valid();
        bit ok;
        ok = (win_start < DAY_MINUTES) && (win_end < DAY_MINUTES) && (win_start < win_end)
            && !(day_mask != 7'd0 && dates_used != 0) && (dates_used <= SLOT_COUNT);
        for (int i = 0; i < SLOT_COUNT; i++)
            if (i < dates_used && !slot_date_ok[3'(i)])
                ok = 1'b0;
        return ok;
    endfunction

    // answer of one item, updating the date table on a load
    function automatic answer_t window_answer(input query_t q);
        answer_t a;
        int      now;
        a.in_window = 1'b0;
        if (q.req_type == cwm_pkg::REQ_LOAD) begin
            slot_date[q.slot]    = q.date;
            slot_date_ok[q.slot] = date_is_valid(q.date);
            a.status = cwm_pkg::ST_LOADED;
        end else if (!window_valid()) begin
            a.status = cwm_pkg::ST_BAD_WINDOW;
        end else if (q.hour >= 24 || q.minute >= 60 || !date_is_valid(q.date)) begin
            a.status = cwm_pkg::ST_BAD_TIME;
        end else begin
            a.status = cwm_pkg::ST_CHECKED;
            now = int'(q.hour) * 60 + int'(q.minute);
            if (now >= win_start && now < win_end) begin
                if (day_mask != 7'd0)
                    a.in_window = (q.weekday != cwm_pkg::WEEKDAY_NONE) && day_mask[q.weekday];
                else if (dates_used == 0)
                    a.in_window = 1'b1;
                else
                    for (int i = 0; i < SLOT_COUNT; i++)
                        if (i < dates_used && slot_date[3'(i)] == q.date)
                            a.in_window = 1'b1;
            end
        end
        return a;
    endfunction

    function automatic query_t mk(input logic req, input int slot, input int y, input int m,
                                  input int d, input int wd, input int h, input int mi);
        query_t q;
        q.req_type   = req;
        q.slot       = 3'(slot);
        q.date.year  = 14'(y);
        q.date.month = 4'(m);
        q.date.day   = 5'(d);
        q.weekday    = 3'(wd);
        q.hour       = 5'(h);
        q.minute     = 6'(mi);
        return q;
    endfunction

    // legal date, leaning on century and leap years and the year extremes
    function automatic cwm_pkg::date_t random_good_date();
        cwm_pkg::date_t d;
        int             y;
        int             m;
        case ($urandom_range(0, 7))
            0:       y = 1;
            1:       y = 9999;
            2:       y = 1900;
            3:       y = 2000;
            4:       y = 2100;
            5:       y = 4 * $urandom_range(1, 2499);
            default: y = $urandom_range(1, 9999);
        endcase
        m = ($urandom_range(0, 5) == 0) ? 2 : $urandom_range(1, 12);
        d.year  = 14'(y);
        d.month = 4'(m);
        if ($urandom_range(0, 3) == 0)
            d.day = 5'(days_of_month(y, m));
        else
            d.day = 5'($urandom_range(1, days_of_month(y, m)));
        return d;
    endfunction

    // a legal date broken in one way: non-leap Feb 29, day 0, April 31, bad month or bad year
    function automatic cwm_pkg::date_t random_bad_date();
        cwm_pkg::date_t d;
        d = random_good_date();
        case ($urandom_range(0, 4))
            0: begin
                d.year  = ($urandom_range(0, 1) == 0) ? 14'd1900 : 14'd2023;
                d.month = cwm_pkg::FEBRUARY;
                d.day   = 5'd29;
            end
            1: d.day = 5'd0;
            2: begin
                d.month = 4'd4;
                d.day   = 5'd31;
            end
            3: d.month = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
            default: d.year = ($urandom_range(0, 3) == 0) ? 14'd0
                                                          : 14'($urandom_range(10000, 16383));
        endcase
        return d;
    endfunction

    function automatic query_t make_load(input int slot, input bit good_only);
        query_t q;
        q.req_type = cwm_pkg::REQ_LOAD;
        q.slot     = 3'(slot);
        q.date     = (!good_only && $urandom_range(0, 6) == 0) ? random_bad_date()
                                                               : random_good_date();
        q.weekday  = 3'($urandom);
        q.hour     = 5'($urandom);
        q.minute   = 6'($urandom);
        return q;
    endfunction

    // check item: mostly well formed, times near the window and dates from the table
    function automatic query_t make_check();
        query_t q;
        int     pick;
        int     now;
        int     used;
        q.req_type = cwm_pkg::REQ_CHECK;
        q.slot     = 3'($urandom);
        pick = $urandom_range(0, 19);
        used = (dates_used < SLOT_COUNT) ? dates_used : SLOT_COUNT;
        if (pick < 3)
            q.date = random_bad_date();
        else if (used != 0 && pick < 12)
            q.date = slot_date[3'($urandom_range(0, used - 1))];
        else
            q.date = random_good_date();
        if ($urandom_range(0, 7) == 0)
            q.weekday = cwm_pkg::WEEKDAY_NONE;
        else
            q.weekday = 3'($urandom_range(0, 6));
        now = $urandom_range(0, DAY_MINUTES - 1);
        if (win_start < win_end && win_end <= DAY_MINUTES) begin
            case ($urandom_range(0, 9))
                0:       now = win_start;
                1:       now = win_end - 1;
                2:       now = win_end;
                3:       now = win_start - 1;
                4, 5:    ;
                default: now = $urandom_range(win_start, win_end - 1);
            endcase
            if (now < 0 || now >= DAY_MINUTES)
                now = $urandom_range(0, DAY_MINUTES - 1);
        end
        q.hour   = 5'(now / 60);
        q.minute = 6'(now % 60);
        // out of range clock fields and pure noise
        if (pick == 3) begin
            if ($urandom_range(0, 1) == 0)
                q.hour = 5'($urandom_range(24, 31));
            else
                q.minute = 6'($urandom_range(60, 63));
        end else if (pick == 4) begin
            q.date    = 23'($urandom);
            q.weekday = 3'($urandom);
            q.hour    = 5'($urandom);
            q.minute  = 6'($urandom);
        end
        return q;
    endfunction

    // wait until no item is queued, in flight or unanswered
    task automatic settle();
        @(negedge clk);
        while (pending_queries.size() != 0 || q_busy || q_taken || answers_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // all four registers, spare high bits of mask and count filled with noise
    task automatic program_window(input int s, input int e, input int mask, input int count);
        logic [10:0] mask_data;
        logic [10:0] count_data;
        settle();
        mask_data  = 11'(($urandom & 32'h780) | (mask & 32'h7F));
        count_data = 11'(($urandom & 32'h7F0) | (count & 32'hF));
        write_reg(cwm_pkg::CFG_START, 11'(s));
        write_reg(cwm_pkg::CFG_END, 11'(e));
        write_reg(cwm_pkg::CFG_MASK, mask_data);
        write_reg(cwm_pkg::CFG_COUNT, count_data);
        cfg_we     <= 1'b0;
        win_start  = s & 32'h7FF;
        win_end    = e & 32'h7FF;
        day_mask   = mask_data[6:0];
        dates_used = int'(count_data[3:0]);
    endtask

    // query driver: acceptance seen at the rising edge, prediction and next item at the falling
    always @(posedge clk)
        if (rst_n && query_ch.valid && query_ch.ready)
            q_taken = 1'b1;

    always @(negedge clk) begin
        if (q_taken) begin
            answers_due.push_back(window_answer(current_query));
            q_taken = 1'b0;
            q_busy  = 1'b0;
        end
        if (!q_busy) begin
            if (q_gap > 0) begin
                q_gap--;
                query_ch.valid <= 1'b0;
            end else if (pending_queries.size() != 0) begin
                current_query = pending_queries.pop_front();
                query_ch.valid          <= 1'b1;
                query_ch.req_type       <= current_query.req_type;
                query_ch.slot           <= current_query.slot;
                query_ch.year           <= current_query.date.year;
                query_ch.month          <= current_query.date.month;
                query_ch.day            <= current_query.date.day;
                query_ch.weekday        <= current_query.weekday;
                query_ch.hour           <= current_query.hour;
                query_ch.minute_of_hour <= current_query.minute;
                q_busy = 1'b1;
                if (idling_on && $urandom_range(0, 4) == 0)
                    q_gap = $urandom_range(1, 10);
            end else begin
                query_ch.valid <= 1'b0;
            end
        end
    end

    // answer receiver with stall bursts
    always @(negedge clk) begin
        if (a_gap > 0) begin
            a_gap--;
            answer_ch.ready <= 1'b0;
        end else begin
            answer_ch.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0)
                a_gap = $urandom_range(1, 10);
        end
    end

    // answer monitor
    always @(posedge clk) begin
        answer_t want;
        if (rst_n && answer_ch.valid && answer_ch.ready) begin
            if (answers_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: answer with none due: in_window=%0b status=%0d",
                             $time, answer_ch.in_window, answer_ch.status);
            end else begin
                want = answers_due.pop_front();
                if (answer_ch.in_window !== want.in_window) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: in_window mismatch: expected %0b actual %0b",
                                 $time, want.in_window, answer_ch.in_window);
                end
                if (answer_ch.status !== want.status) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, answer_ch.status);
                end
                case (want.status)
                    cwm_pkg::ST_CHECKED:    if (want.in_window) n_hit++; else n_miss++;
                    cwm_pkg::ST_BAD_WINDOW: n_bad_window++;
                    cwm_pkg::ST_BAD_TIME:   n_bad_time++;
                    default:                n_loaded++;
                endcase
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    // stimulus sequence
    initial begin
        int s;
        int e;
        int mask;
        int count;
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = cwm_pkg::CFG_START;
        cfg_data                = '0;
        query_ch.valid          = 1'b0;
        query_ch.req_type       = cwm_pkg::REQ_LOAD;
        query_ch.slot           = '0;
        query_ch.year           = '0;
        query_ch.month          = '0;
        query_ch.day            = '0;
        query_ch.weekday        = '0;
        query_ch.hour           = '0;
        query_ch.minute_of_hour = '0;
        answer_ch.ready         = 1'b0;
        win_start  = 0;
        win_end    = 0;
        day_mask   = '0;
        dates_used = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_date[3'(i)]    = '0;
            slot_date_ok[3'(i)] = 1'b0;
        end
        idling_on = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset leaves start equal to end, so the window is invalid
        @(posedge clk);
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 6, 15, 6, 12, 30));
        // slots: leap years, century rule, year extremes, malformed dates
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 0, 2024, 2, 29, 0, 0, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 1, 1900, 2, 29, 0, 0, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 2, 2000, 2, 29, 0, 0, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 3, 9999, 12, 31, 7, 31, 63));
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 4, 1, 1, 1, 0, 0, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 5, 0, 1, 1, 0, 0, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 6, 16383, 15, 31, 0, 0, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 7, 2023, 4, 31, 0, 0, 0));

        // whole day, no selection: day edges and bad time and date fields
        program_window(0, 1439, 0, 0);
        @(posedge clk);
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 1, 1, 1, 0, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 1, 1, 1, 23, 58));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 1, 1, 1, 23, 59));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 1, 1, 1, 24, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 1, 1, 1, 12, 60));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 1, 1, 1, 31, 63));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 13, 1, 1, 12, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 1, 0, 1, 12, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 10000, 1, 1, 1, 12, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2100, 2, 29, 1, 12, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 1, 1, 7, 12, 0));

        // weekend mask, 10:00 to 12:00
        program_window(600, 720, 7'b1000001, 0);
        @(posedge clk);
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 6, 16, 0, 10, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 6, 15, 6, 11, 59));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 6, 15, 7, 10, 30));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 6, 16, 0, 12, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 6, 19, 3, 10, 30));

        // three dates in use, one of them bad until reloaded
        program_window(0, 1439, 0, 3);
        @(posedge clk);
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2000, 2, 29, 2, 8, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_LOAD, 1, 2024, 12, 25, 0, 0, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2000, 2, 29, 2, 8, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 12, 25, 3, 8, 0));
        pending_queries.push_back(mk(cwm_pkg::REQ_CHECK, 0, 2024, 12, 26, 4, 8, 0));

        // random rounds, each under its own window setting
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            case ($urandom_range(0, 13))
                0: begin s = 0;    e = 1439; end
                1: begin s = 1438; e = 1439; end
                2: begin s = 0;    e = 1; end
                3: begin s = $urandom_range(0, 1439); e = s; end
                4: begin s = $urandom_range(0, 2047); e = $urandom_range(0, 2047); end
                5: begin s = $urandom_range(0, 1438); e = $urandom_range(1440, 2047); end
                6: begin s = $urandom_range(1440, 2047); e = 2047; end
                default: begin
                    s = $urandom_range(0, 1438);
                    e = $urandom_range(s + 1, 1439);
                end
            endcase
            mask  = 0;
            count = 0;
            case ($urandom_range(0, 7))
                0: ;
                1: mask = 127;
                2, 3: mask = $urandom_range(1, 127);
                4, 5: count = $urandom_range(1, SLOT_COUNT);
                6: count = SLOT_COUNT;
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        mask  = $urandom_range(1, 127);
                        count = $urandom_range(1, 15);
                    end else begin
                        count = $urandom_range(SLOT_COUNT + 1, 15);
                    end
                end
            endcase
            program_window(s, e, mask, count);
            idling_on = (round < RANDOM_ROUNDS - 2) && ($urandom_range(0, 3) != 0);
            @(posedge clk);
            // refill the slots in use with good dates most of the time
            if (count != 0 && $urandom_range(0, 3) != 0) begin
                for (int i = 0; i < count && i < SLOT_COUNT; i++)
                    pending_queries.push_back(make_load(i, 1'b1));
                settle();
                @(posedge clk);
            end
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0)
                    pending_queries.push_back(make_load($urandom_range(0, SLOT_COUNT - 1), 1'b0));
                else
                    pending_queries.push_back(make_check());
            end
        end

        // drain, then watch for stray answers
        settle();
        repeat (SLOT_COUNT + 4) @(negedge clk);
        $display("answers: %0d in window, %0d outside, %0d bad window, %0d bad time",
                 n_hit, n_miss, n_bad_window, n_bad_time);
        $display("date loads: %0d, window settings: %0d, cycles: %0d",
                 n_loaded, RANDOM_ROUNDS + 4, cycle_count);
        if (errors == 0 && answers_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
